// ----- rtl/tedet_pkg.sv -----
package tedet_pkg;

  typedef enum logic [1:0] {
    ENC_ANSI = 2'd0,
    ENC_UTF8 = 2'd1,
    ENC_LE   = 2'd2,
    ENC_BE   = 2'd3
  } enc_e;

  // first three bytes of a buffer, index 0 is the first byte
  typedef logic [2:0][7:0] prefix_t;

  typedef struct packed {
    logic ok;        // strict UTF-8 check passes with the current byte included
    logic seq_open;  // a multi-byte sequence is still awaiting continuations
  } chk_res_t;

  localparam logic [7:0] BomUtf8B0 = 8'hEF;
  localparam logic [7:0] BomUtf8B1 = 8'hBB;
  localparam logic [7:0] BomUtf8B2 = 8'hBF;
  localparam logic [7:0] BomFe     = 8'hFE;
  localparam logic [7:0] BomFf     = 8'hFF;
  localparam logic [7:0] ChBracket = 8'h5B;
  localparam logic [7:0] ChBrace   = 8'h7B;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ContLow   = 8'h80;
  localparam logic [7:0] ContHigh  = 8'hBF;

  function automatic enc_e classify(prefix_t p, logic ok);
    enc_e enc;
    if (p[0] == BomUtf8B0 && p[1] == BomUtf8B1 && p[2] == BomUtf8B2) begin
      enc = ENC_UTF8;
    end else if (p[0] == BomFe && p[1] == BomFf) begin
      enc = ENC_BE;
    end else if (p[0] == BomFf && p[1] == BomFe) begin
      enc = ENC_LE;
    end else if (p[0] == 8'h00) begin
      enc = ENC_BE;
    end else if ((p[0] == ChBracket || p[0] == ChBrace || p[0] == ChSlash) &&
                 p[1] == 8'h00) begin
      enc = ENC_LE;
    end else begin
      enc = ok ? ENC_UTF8 : ENC_ANSI;
    end
    return enc;
  endfunction

endpackage

// ----- rtl/tedet_utf8_chk.sv -----
module tedet_utf8_chk import tedet_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output chk_res_t   res_o
);

  logic [1:0] cont_q, cont_d, upd_cont;
  logic [7:0] lo_q, lo_d, upd_lo;
  logic [7:0] hi_q, hi_d, upd_hi;
  logic       ok_q, ok_d, upd_ok;
  logic       zero_q, zero_d, upd_zero;

  always_comb begin
    upd_cont = cont_q;
    upd_lo   = lo_q;
    upd_hi   = hi_q;
    upd_ok   = ok_q;
    upd_zero = zero_q;
    if (zero_q || !ok_q) begin
      // check has already ended, hold
    end else if (cont_q != 2'd0) begin
      if (byte_i >= lo_q && byte_i <= hi_q) begin
        upd_cont = cont_q - 2'd1;
        upd_lo   = ContLow;
        upd_hi   = ContHigh;
      end else begin
        upd_ok = 1'b0;
      end
    end else begin
      case (byte_i) inside
        8'h00: upd_zero = 1'b1;
        8'h09, 8'h0A, 8'h0D, [8'h20:8'h7E]: ;
        [8'hC2:8'hDF]: begin
          upd_cont = 2'd1; upd_lo = ContLow; upd_hi = ContHigh;
        end
        8'hE0: begin
          upd_cont = 2'd2; upd_lo = 8'hA0; upd_hi = ContHigh;
        end
        8'hED: begin
          upd_cont = 2'd2; upd_lo = ContLow; upd_hi = 8'h9F;
        end
        [8'hE1:8'hEC], 8'hEE, 8'hEF: begin
          upd_cont = 2'd2; upd_lo = ContLow; upd_hi = ContHigh;
        end
        8'hF0: begin
          upd_cont = 2'd3; upd_lo = 8'h90; upd_hi = ContHigh;
        end
        [8'hF1:8'hF3]: begin
          upd_cont = 2'd3; upd_lo = ContLow; upd_hi = ContHigh;
        end
        8'hF4: begin
          upd_cont = 2'd3; upd_lo = ContLow; upd_hi = 8'h8F;
        end
        default: upd_ok = 1'b0;
      endcase
    end
  end

  // an unfinished sequence fails unless a zero byte stopped the check first
  assign res_o.ok       = upd_ok && (upd_zero || upd_cont == 2'd0);
  assign res_o.seq_open = cont_q != 2'd0;

  always_comb begin
    cont_d = cont_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    ok_d   = ok_q;
    zero_d = zero_q;
    if (acc_i) begin
      if (last_i) begin
        // restart for the next buffer
        cont_d = 2'd0;
        lo_d   = ContLow;
        hi_d   = ContHigh;
        ok_d   = 1'b1;
        zero_d = 1'b0;
      end else begin
        cont_d = upd_cont;
        lo_d   = upd_lo;
        hi_d   = upd_hi;
        ok_d   = upd_ok;
        zero_d = upd_zero;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q <= 2'd0;
      lo_q   <= ContLow;
      hi_q   <= ContHigh;
      ok_q   <= 1'b1;
      zero_q <= 1'b0;
    end else begin
      cont_q <= cont_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      ok_q   <= ok_d;
      zero_q <= zero_d;
    end
  end

endmodule

// ----- rtl/tedet_prefix.sv -----
module tedet_prefix import tedet_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output prefix_t    prefix_o
);

  prefix_t    pre_q, pre_d, upd_pre;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    upd_pre = pre_q;
    for (int i = 0; i < 3; i++) begin
      if (cnt_q == 2'(i)) begin
        upd_pre[i] = byte_i;
      end
    end
  end

  // prefix including the current byte; unfilled slots stay zero
  assign prefix_o = upd_pre;

  always_comb begin
    pre_d = pre_q;
    cnt_d = cnt_q;
    if (acc_i) begin
      if (last_i) begin
        pre_d = '0;
        cnt_d = 2'd0;
      end else begin
        pre_d = upd_pre;
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= '0;
      cnt_q <= 2'd0;
    end else begin
      pre_q <= pre_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/text_encoding_detector.sv -----
// Text encoding detector. Stream a buffer in one byte per request, with tlast
// on the final byte; one result follows each buffer, carrying the detected
// encoding (ANSI, UTF-8, UTF-16LE, UTF-16BE) from byte-order-mark and prefix
// rules, and the outcome of a strict UTF-8 check. A byte is taken every clock
// while the result register is empty or being drained; the result appears in the
// cycle after the last byte is accepted, loaded by the single pass of prefix and
// UTF-8 decode logic feeding the result register. The result payload has no reset.
module text_encoding_detector import tedet_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [1:0] encoding, [2] utf8_valid, [7:3] zero
);

  logic     in_acc;
  chk_res_t chk_res;
  prefix_t  prefix;
  logic     m_valid_q, m_valid_d;
  enc_e     enc_q;
  logic     valid_bit_q;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  tedet_utf8_chk u_chk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .res_o  (chk_res)
  );

  tedet_prefix u_prefix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .prefix_o (prefix)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (in_acc && s_axis_tlast_i) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  // result payload, loaded on the final byte
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast_i) begin
      enc_q       <= classify(prefix, chk_res.ok);
      valid_bit_q <= chk_res.ok;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, valid_bit_q, enc_q};

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(in_acc && s_axis_tlast_i))
    else $error("result without a final byte");

  a_ansi_only_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && enc_q == ENC_ANSI) |-> !valid_bit_q)
    else $error("ANSI reported with a passing UTF-8 check");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !(m_valid_q && !m_axis_tready_i))
    else $error("request accepted while result stalled");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> !chk_res.seq_open)
    else $error("check state not cleared after final byte");

endmodule
